// ===== sv/reciprocal_square_multiplier_search_assert.svh =====
// Assertion macros shared by the reciprocal square multiplier search RTL.
`ifndef RECIPROCAL_SQUARE_MULTIPLIER_SEARCH_ASSERT_SVH
`define RECIPROCAL_SQUARE_MULTIPLIER_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while the active-low reset is applied.
`define RSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed in reciprocal square multiplier search");

// Next-cycle implication, disabled while the active-low reset is applied.
`define RSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed in reciprocal square multiplier search");

`endif

// ===== sv/rsm_pkg.sv =====
// Package with the field widths of the reciprocal square multiplier search.
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int unsigned WINDOW_W = 8;
  localparam int unsigned TOL_W    = 32;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned MULT_W   = 16;

endpackage

// ===== sv/rsm_if.sv =====
// Request and result channel interfaces of the reciprocal square multiplier search.
`timescale 1ns / 1ps
interface rsm_req_if import rsm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [WINDOW_W-1:0] window_size;
  logic [TOL_W-1:0]    tolerance;

  modport source (output valid, output window_size, output tolerance, input ready);
  modport sink   (input valid, input window_size, input tolerance, output ready);
endinterface

interface rsm_res_if import rsm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SHIFT_W-1:0] shift_exponent;
  logic [MULT_W-1:0]  multiplier;
  logic               found;

  modport source (output valid, output shift_exponent, output multiplier, output found,
                  input ready);
  modport sink   (input valid, input shift_exponent, input multiplier, input found,
                  output ready);
endinterface

// ===== sv/reciprocal_square_multiplier_search.sv =====
// Top level of the reciprocal square multiplier search for average pooling.
`timescale 1ns / 1ps
`include "reciprocal_square_multiplier_search_assert.svh"
// For a window side w and a Q0.32 relative tolerance, the block returns the first shift k
// and multiplier m, with m the rounded-up quotient of 2^k by w*w tried before the rounded-down
// one, whose relative error is strictly below the tolerance; otherwise all fields are zero
// and found is low. After a request is accepted, the square state forms w*w; then each shift
// tests its two candidates in turn on a single shared error comparator, while one
// restoring-division bit a shift advances quotient and remainder. A zero window goes from
// the square state straight to done. A new request is taken once the search is idle, even
// while the last result still waits.
module reciprocal_square_multiplier_search import rsm_pkg::*; #(
  parameter int unsigned SEARCH_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsm_req_if.sink   req_i,
  rsm_res_if.source res_o
);

  localparam int unsigned KW = (SEARCH_STEPS > 1) ? $clog2(SEARCH_STEPS) : 1;
  localparam int unsigned QW = (SEARCH_STEPS > MULT_W) ? SEARCH_STEPS : MULT_W;
  localparam int unsigned TW = TOL_W + SEARCH_STEPS;
  localparam int unsigned LW = MULT_W + TOL_W;
  localparam int unsigned CW = (TW > LW) ? TW : LW;
  localparam int unsigned DW = 2 * WINDOW_W;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SQUARE  = 5'b00010,
    ST_TEST_HI = 5'b00100,
    ST_TEST_LO = 5'b01000,
    ST_DONE    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [WINDOW_W-1:0] w_q;
  logic [TW-1:0]       tol_sh_q, tol_sh_d;
  logic [DW-1:0]       d_q, d_d;
  logic [DW-1:0]       r_q, r_d;
  logic [QW-1:0]       q_q, q_d;
  logic [KW-1:0]       k_q, k_d;
  logic [SHIFT_W-1:0]  fnd_k_q, fnd_k_d;
  logic [MULT_W-1:0]   fnd_m_q, fnd_m_d;
  logic                fnd_f_q, fnd_f_d;
  logic                out_valid_q, out_valid_d;
  logic [SHIFT_W-1:0]  out_k_q;
  logic [MULT_W-1:0]   out_m_q;
  logic                out_f_q;

  logic                req_fire;
  logic                out_load;
  logic                r_nz;
  logic                last_step;
  logic [DW-1:0]       diff;
  logic                pass;
  logic [QW-1:0]       hi_cand;
  logic [DW:0]         r2;
  logic                r2_ge;
  logic [DW:0]         r2_sub;
  logic [KW+SHIFT_W-1:0] k_ext;

  assign req_fire  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  assign r_nz      = (r_q != '0);
  assign last_step = (k_q == KW'(SEARCH_STEPS - 1));
  assign hi_cand   = q_q + QW'(r_nz);
  assign k_ext     = {{SHIFT_W{1'b0}}, k_q};

  // The shared comparator tests |m*d - 2^k| * 2^32 against tolerance * 2^k.
  always_comb begin
    if (state_q == ST_TEST_HI) begin
      diff = r_nz ? (d_q - r_q) : '0;
    end else begin
      diff = r_q;
    end
  end
  assign pass = CW'({diff, {TOL_W{1'b0}}}) < CW'(tol_sh_q);

  assign r2     = {r_q, 1'b0};
  assign r2_ge  = (r2 >= {1'b0, d_q});
  assign r2_sub = r2 - {1'b0, d_q};

  always_comb begin
    state_d     = state_q;
    tol_sh_d    = tol_sh_q;
    d_d         = d_q;
    r_d         = r_q;
    q_d         = q_q;
    k_d         = k_q;
    fnd_k_d     = fnd_k_q;
    fnd_m_d     = fnd_m_q;
    fnd_f_d     = fnd_f_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          tol_sh_d = TW'(req_i.tolerance);
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        d_d     = DW'(w_q * w_q);
        k_d     = '0;
        fnd_k_d = '0;
        fnd_m_d = '0;
        fnd_f_d = 1'b0;
        if (w_q == WINDOW_W'(1)) begin
          q_d = QW'(1);
          r_d = '0;
        end else begin
          q_d = '0;
          r_d = DW'(1);
        end
        state_d = (w_q == '0) ? ST_DONE : ST_TEST_HI;
      end
      ST_TEST_HI: begin
        if (pass) begin
          fnd_k_d = k_ext[SHIFT_W-1:0];
          fnd_m_d = hi_cand[MULT_W-1:0];
          fnd_f_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_TEST_LO;
        end
      end
      ST_TEST_LO: begin
        if (pass) begin
          fnd_k_d = k_ext[SHIFT_W-1:0];
          fnd_m_d = q_q[MULT_W-1:0];
          fnd_f_d = 1'b1;
          state_d = ST_DONE;
        end else if (last_step) begin
          state_d = ST_DONE;
        end else begin
          r_d      = r2_ge ? r2_sub[DW-1:0] : r2[DW-1:0];
          q_d      = {q_q[QW-2:0], r2_ge};
          tol_sh_d = {tol_sh_q[TW-2:0], 1'b0};
          k_d      = k_q + KW'(1);
          state_d  = ST_TEST_HI;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      w_q <= req_i.window_size;
    end
    tol_sh_q <= tol_sh_d;
    d_q      <= d_d;
    r_q      <= r_d;
    q_q      <= q_d;
    k_q      <= k_d;
    fnd_k_q  <= fnd_k_d;
    fnd_m_q  <= fnd_m_d;
    fnd_f_q  <= fnd_f_d;
    if (out_load) begin
      out_k_q <= fnd_k_q;
      out_m_q <= fnd_m_q;
      out_f_q <= fnd_f_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.shift_exponent = out_k_q;
  assign res_o.multiplier     = out_m_q;
  assign res_o.found          = out_f_q;

  `RSM_ASSERT_IMPL(a_not_found_zero, clk_i, rst_ni, out_valid_q && !out_f_q,
                   (out_k_q == '0) && (out_m_q == '0))
  `RSM_ASSERT_IMPL(a_rem_below_div, clk_i, rst_ni,
                   (state_q == ST_TEST_HI) || (state_q == ST_TEST_LO), r_q < d_q)
  `RSM_ASSERT_IMPL(a_step_in_range, clk_i, rst_ni,
                   (state_q == ST_TEST_HI) || (state_q == ST_TEST_LO),
                   k_q <= KW'(SEARCH_STEPS - 1))
  `RSM_ASSERT_NEXT(a_step_advance, clk_i, rst_ni,
                   (state_q == ST_TEST_LO) && !pass && !last_step,
                   (k_q == $past(k_q) + KW'(1)) && (state_q == ST_TEST_HI))

endmodule
